FILE: rtl/ssis_pkg.sv
// ----------------------------------------------------------------------------
// ssis_pkg
// Shared types and constants for the sorted set with insert and search.
// ----------------------------------------------------------------------------
package ssis_pkg;

    localparam int CAPACITY_DEF = 256;

    // request codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_PRESENT   = 3'd2,
        ST_ABSENT    = 3'd3,
        ST_FULL      = 3'd4
    } status_code_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOP,
        S_CMP,
        S_SHIFT,
        S_SHWR,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request, start search window
        logic mid_rd;    // read the probe slot
        logic srch_cmp;  // narrow the window with the probe data
        logic shift_rd;  // read the slot below the shift index
        logic shift_wr;  // move that key up one slot
        logic ins_wr;    // store the new key, bump the count
        logic out_load;  // latch the result into the output register
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic srch_more;  // search window not empty
        logic do_insert;  // insert of a new key with room left
        logic shift_more; // larger keys still to move
        logic out_busy;   // output register holds an untaken result
    } ctrl_stat_t;

endpackage

FILE: rtl/ssis_ram.sv
// ----------------------------------------------------------------------------
// ssis_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ssis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ssis_ctrl.sv
// ----------------------------------------------------------------------------
// ssis_ctrl
// Sequencer: binary search probes, shift of larger keys, result hand-off.
// ----------------------------------------------------------------------------
module ssis_ctrl import ssis_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  ctrl_stat_t st,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_LOOP;
                end
            end
            S_LOOP:
            begin
                priority if (st.srch_more)
                begin
                    state_next = S_CMP;
                end
                else if (st.do_insert)
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_CMP:
            begin
                state_next = S_LOOP;
            end
            S_SHIFT:
            begin
                if (st.shift_more)
                begin
                    state_next = S_SHWR;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SHWR:
            begin
                state_next = S_SHIFT;
            end
            S_DONE:
            begin
                if (!st.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_LOOP:
            begin
                cmd.mid_rd = st.srch_more;
            end
            S_CMP:
            begin
                cmd.srch_cmp = 1'b1;
            end
            S_SHIFT:
            begin
                cmd.shift_rd = st.shift_more;
                cmd.ins_wr   = !st.shift_more;
            end
            S_SHWR:
            begin
                cmd.shift_wr = 1'b1;
            end
            S_DONE:
            begin
                cmd.out_load = !st.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/ssis_dp.sv
// ----------------------------------------------------------------------------
// ssis_dp
// Datapath: key store, search window, shift index, count and output register.
// ----------------------------------------------------------------------------
module ssis_dp import ssis_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int CW       = $clog2(CAPACITY + 1),
    parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          cmd,
    output ctrl_stat_t         st,
    input  logic               op,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic [CW-1:0]      set_size
);

    logic signed [31:0] key_reg;
    logic               op_reg;
    logic               found_reg;
    logic               full_reg;
    logic [CW-1:0]      lo_reg;
    logic [CW-1:0]      hi_reg;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      cnt_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    status_code_t       status_reg;
    logic [CW-1:0]      set_size_reg;

    logic [CW-1:0]      mid;
    logic [CW-1:0]      idx_m1;
    logic               full;
    logic signed [31:0] rdata;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [31:0]        ram_wdata;
    logic [AW-1:0]      ram_raddr;
    status_code_t       result;

    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign idx_m1 = idx_reg - CW'(1);
    assign full   = (cnt_reg == CW'(CAPACITY));

    assign ram_we    = cmd.shift_wr | cmd.ins_wr;
    assign ram_waddr = cmd.shift_wr ? idx_reg[AW-1:0] : lo_reg[AW-1:0];
    assign ram_wdata = cmd.shift_wr ? rdata : key_reg;
    assign ram_raddr = cmd.mid_rd ? mid[AW-1:0] : idx_m1[AW-1:0];

    ssis_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    // keys are distinct, so a probe hit means the final window lands on it
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg   <= value;
            op_reg    <= op;
            found_reg <= 1'b0;
            full_reg  <= full;
            lo_reg    <= '0;
            hi_reg    <= cnt_reg;
            idx_reg   <= cnt_reg;
        end
        if (cmd.srch_cmp)
        begin
            if (rdata < key_reg)
            begin
                lo_reg <= mid + CW'(1);
            end
            else
            begin
                hi_reg <= mid;
            end
            if (rdata == key_reg)
            begin
                found_reg <= 1'b1;
            end
        end
        if (cmd.shift_wr)
        begin
            idx_reg <= idx_m1;
        end
        if (cmd.out_load)
        begin
            status_reg   <= result;
            set_size_reg <= cnt_reg;
        end
    end

    // fullness as seen when the request was taken, the count may have moved since
    always_comb
    begin
        priority if (op_reg == OP_SEARCH)
        begin
            result = found_reg ? ST_PRESENT : ST_ABSENT;
        end
        else if (found_reg)
        begin
            result = ST_DUPLICATE;
        end
        else if (full_reg)
        begin
            result = ST_FULL;
        end
        else
        begin
            result = ST_INSERTED;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.ins_wr)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign st.srch_more  = (lo_reg < hi_reg);
    assign st.do_insert  = (op_reg == OP_INSERT) && !found_reg && !full_reg;
    assign st.shift_more = (idx_reg > lo_reg);
    assign st.out_busy   = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign set_size  = set_size_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(CAPACITY))
        else $error("key count above capacity");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_wr |=> cnt_reg == $past(cnt_reg) + CW'(1))
        else $error("insert did not bump the key count");

    a_probe_window: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.srch_cmp |-> lo_reg < hi_reg)
        else $error("probe compare with an empty search window");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_wr |-> idx_reg > lo_reg && idx_reg < CW'(CAPACITY))
        else $error("shift write outside the moved range");

endmodule

FILE: rtl/sorted_set_insert_search.sv
// ----------------------------------------------------------------------------
// sorted_set_insert_search
// Sorted set of signed 32-bit keys: insert and search with binary search.
// ----------------------------------------------------------------------------
// Keys live in ascending order in one RAM with a registered read port, so
// every binary search probe is an address step followed by a compare step.
// A search, a duplicate insert or a refused insert ends with the search;
// an insert of a new key then moves each larger key up one slot, a read and
// a write per key, and ends with the write of the new key. One request is in
// flight at a time; the result sits in an output register, and the next
// request is taken as soon as the result has been latched there, even if it
// has not yet been taken.
module sorted_set_insert_search import ssis_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic [CW-1:0]      set_size
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    ctrl_cmd_t  cmd;
    ctrl_stat_t st;

    ssis_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    ssis_dp #(
        .CAPACITY (CAPACITY),
        .CW       (CW),
        .AW       (AW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .op        (op),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .set_size  (set_size)
    );

endmodule

FILE: tb/sorted_set_insert_search_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_set_insert_search_test
// Self-checking bench for the sorted key set: a scoreboard keeps its own
// ascending key list, predicts status and set size for every request taken,
// and checks each result in order, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module sorted_set_insert_search_test;
    import ssis_pkg::*;

    localparam int SIZE_W       = $clog2(CAPACITY_DEF + 1);
    localparam int RANDOM_ITEMS = 830;
    localparam int TAIL_ITEMS   = 100;
    localparam int HOLD_CYCLES  = 2000;

    class key_set_scoreboard;
        logic signed [31:0] keys[$];
        status_code_t       exp_status[$];
        logic [SIZE_W-1:0]  exp_size[$];
        int                 failures;
        int                 results_seen;

        function int lower_slot(logic signed [31:0] v);
            int lo;
            int hi;
            int mid;
            lo = 0;
            hi = keys.size();
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (keys[mid] < v)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            return lo;
        endfunction

        function void note_request(logic req_op, logic signed [31:0] v);
            int           pos;
            bit           found;
            status_code_t st;
            pos = lower_slot(v);
            found = (pos < keys.size()) && (keys[pos] == v);
            if (req_op == OP_SEARCH)
                st = found ? ST_PRESENT : ST_ABSENT;
            else if (found)
                st = ST_DUPLICATE;
            else if (keys.size() >= CAPACITY_DEF)
                st = ST_FULL;
            else
            begin
                keys.insert(pos, v);
                st = ST_INSERTED;
            end
            exp_status.push_back(st);
            exp_size.push_back(SIZE_W'(keys.size()));
        endfunction

        function void check_result(logic [2:0] st, logic [SIZE_W-1:0] sz);
            status_code_t want_st;
            logic [SIZE_W-1:0] want_sz;
            results_seen++;
            if (exp_status.size() == 0)
            begin
                $error("unexpected result: status %0d set_size %0d", st, sz);
                failures++;
                return;
            end
            want_st = exp_status.pop_front();
            want_sz = exp_size.pop_front();
            if (st !== want_st)
            begin
                $error("status: expected %0d, actual %0d", want_st, st);
                failures++;
            end
            if (sz !== want_sz)
            begin
                $error("set_size: expected %0d, actual %0d", want_sz, sz);
                failures++;
            end
        endfunction

        function int pending();
            return exp_status.size();
        endfunction

        function logic signed [31:0] any_key();
            if (keys.size() == 0)
                return $urandom;
            return keys[$urandom_range(0, keys.size() - 1)];
        endfunction

        function bit is_full();
            return keys.size() >= CAPACITY_DEF;
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                op;
    logic signed [31:0]  value;
    logic                out_valid;
    logic                out_ready;
    logic [2:0]          status;
    logic [SIZE_W-1:0]   set_size;

    key_set_scoreboard sb = new();
    bit                tail_phase;

    sorted_set_insert_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .set_size  (set_size)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // handshakes are settled at the falling edge; the transfer follows at the next rise
    always @(negedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_request(op, value);
        if (rst_n && out_valid && out_ready)
            sb.check_result(status, set_size);
    end

    task automatic send_item(input logic req_op, input logic signed [31:0] v);
        in_valid <= 1'b1;
        op       <= req_op;
        value    <= v;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic idle_cycles(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_key();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 6))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = 32'h0000_0000;
                    3: v = 32'hffff_ffff;
                    4: v = 32'h0000_0001;
                    5: v = 32'h7fff_fffe;
                    default: v = 32'h8000_0001;
                endcase
            end
            1, 2:
            begin
                v = $urandom_range(0, 600);
                v = v - 300;
            end
            3, 4: v = sb.any_key();
            5: v = sb.any_key() + ($urandom_range(0, 1) ? 1 : -1);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // receiver: random ready bursts, one long hold-off, steady ready at the tail
    initial
    begin
        bit held;
        held = 1'b0;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (tail_phase)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else if (!held && sb.results_seen >= 250)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int gap_pct;
        int ins_pct;
        tail_phase = 1'b0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        op       <= OP_INSERT;
        value    <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store, extreme keys, duplicates, hits and misses
        send_item(OP_SEARCH, 32'h0000_0000);
        send_item(OP_INSERT, 32'h0000_0000);
        send_item(OP_INSERT, 32'h7fff_ffff);
        send_item(OP_INSERT, 32'h8000_0000);
        send_item(OP_INSERT, 32'hffff_ffff);
        send_item(OP_INSERT, 32'h0000_0001);
        send_item(OP_INSERT, 32'h0000_0000);
        send_item(OP_INSERT, 32'h8000_0000);
        send_item(OP_INSERT, 32'h7fff_ffff);
        send_item(OP_SEARCH, 32'h7fff_ffff);
        send_item(OP_SEARCH, 32'h8000_0000);
        send_item(OP_SEARCH, 32'h7fff_fffe);
        send_item(OP_SEARCH, 32'h8000_0001);
        send_item(OP_SEARCH, 32'hffff_ffff);
        send_item(OP_SEARCH, 32'h0000_0002);
        wait_drained();

        gap_pct = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 64 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 12;
                    default: gap_pct = 40;
                endcase
            end
            if (i == RANDOM_ITEMS - TAIL_ITEMS)
                tail_phase = 1'b1;
            if (i == 400)
                wait_drained();
            if (!tail_phase && $urandom_range(0, 99) < gap_pct)
                idle_cycles($urandom_range(1, 15));
            // lean on inserts until the store fills so the full case is reached
            ins_pct = sb.is_full() ? 50 : 80;
            send_item(($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_SEARCH, pick_key());
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("sorted_set_insert_search_test OK");
        else
            $display("sorted_set_insert_search_test NOT OK");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("sorted_set_insert_search_test NOT OK");
        $finish;
    end

endmodule
